// ===== rtl/core/block_cache_lru_directory_macros.svh =====
// Assertion helpers shared by the directory modules.
`ifndef BLOCK_CACHE_LRU_DIRECTORY_MACROS_SVH
`define BLOCK_CACHE_LRU_DIRECTORY_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define BCLRU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bclru assertion failed");

// Next-cycle implication, disabled while in reset.
`define BCLRU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bclru assertion failed");

`endif

// ===== rtl/core/bclru_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclru_pkg
// Types and constants of the block cache LRU directory.
// ----------------------------------------------------------------------------
package bclru_pkg;

    localparam int SLOT_W  = 6;
    localparam int STAMP_W = 32;
    localparam int TAG_W   = 32;

    localparam logic [SLOT_W-1:0] SLOT_NONE = 6'd63;

    localparam logic [2:0] REQ_LOOKUP       = 3'd0;
    localparam logic [2:0] REQ_START_READ   = 3'd1;
    localparam logic [2:0] REQ_FINISH_READ  = 3'd2;
    localparam logic [2:0] REQ_FIND_LRU     = 3'd3;
    localparam logic [2:0] REQ_FIND_MRU     = 3'd4;
    localparam logic [2:0] REQ_START_WRITE  = 3'd5;
    localparam logic [2:0] REQ_FINISH_WRITE = 3'd6;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  ark_number;
        logic [23:0] block_number;
        logic [4:0]  entry_index;
        logic        read_ok;
        logic        only_unwritten;
        logic        store_accepts;
    } t_req;

    typedef struct packed {
        logic       found;
        logic [4:0] entry;
        logic       status;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic              load;     // latch request, reset accumulators
        logic              rd;       // scan read issue
        logic [SLOT_W-1:0] rd_addr;
        logic              commit;   // apply updates, load result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/core/bclru_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclru_ctrl
// Sequencer: accepts a request, sweeps the entries for searching requests,
// then commits the result when the output register is free.
// ----------------------------------------------------------------------------
`include "block_cache_lru_directory_macros.svh"

module bclru_ctrl #(
    parameter int NUM_ENTRIES = 19
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [2:0]      i_req_type,
    output logic            o_in_ready,
    input  bclru_pkg::t_sts i_sts,
    output bclru_pkg::t_cmd o_cmd
);

    localparam int IDX_W = $clog2(NUM_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             accept;
    logic             needs_scan;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        case (i_req_type) inside
            bclru_pkg::REQ_LOOKUP, bclru_pkg::REQ_FIND_LRU,
            bclru_pkg::REQ_FIND_MRU, bclru_pkg::REQ_START_WRITE: needs_scan = 1'b1;
            default: needs_scan = 1'b0;
        endcase
    end

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        o_cmd.load     = 1'b0;
        o_cmd.rd       = 1'b0;
        o_cmd.rd_addr  = bclru_pkg::SLOT_W'(r_idx);
        o_cmd.commit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_idx      = '0;
                    n_state    = needs_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_WAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    `BCLRU_ASSERT_IMPL(a_scan_range, i_clk, i_rst_n, r_state == S_SCAN, r_idx <= IDX_LAST)
    `BCLRU_ASSERT_NEXT(a_done_stall, i_clk, i_rst_n, r_state == S_DONE && !i_sts.out_free, r_state == S_DONE)

endmodule

// ===== rtl/core/bclru_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bclru_dpath
// Directory storage, scan compare stage, slot registers, stamp counter and
// output register.
// ----------------------------------------------------------------------------
`include "block_cache_lru_directory_macros.svh"

module bclru_dpath #(
    parameter int NUM_ENTRIES = 19
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bclru_pkg::t_req i_req,
    input  bclru_pkg::t_cmd i_cmd,
    output bclru_pkg::t_sts o_sts,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bclru_pkg::t_rsp o_out_data
);

    localparam int IDX_W  = $clog2(NUM_ENTRIES);
    localparam int SLOT_W = bclru_pkg::SLOT_W;
    localparam int ST_W   = bclru_pkg::STAMP_W;
    localparam logic [SLOT_W-1:0] NUM_SLOT = SLOT_W'(NUM_ENTRIES);

    // tag and stamp memories; entries not yet written read as reset values
    logic [bclru_pkg::TAG_W-1:0] mem_tag   [NUM_ENTRIES];
    logic [ST_W-1:0]             mem_stamp [NUM_ENTRIES];

    logic [NUM_ENTRIES-1:0] r_tag_vld, r_stamp_vld, r_written;
    logic [ST_W-1:0]        r_cnt, n_cnt;
    logic [SLOT_W-1:0]      r_rd_slot, r_wr_slot;
    bclru_pkg::t_req        r_req;

    logic [bclru_pkg::TAG_W-1:0] r_rd_tag;
    logic [ST_W-1:0]             r_rd_stamp;
    logic                        r_p_vld;
    logic [IDX_W-1:0]            r_p_idx;

    logic [ST_W-1:0]  r_best;
    logic [IDX_W-1:0] r_sel;
    logic             r_sel_vld;

    logic            r_out_vld;
    bclru_pkg::t_rsp r_out;

    // compare stage
    logic [SLOT_W-1:0] p_slot;
    logic [ST_W-1:0]   stamp_e;
    logic              tag_hit, only_unw, lru_skip, lru_take, mru_take, refuse_mark;

    // commit decode
    logic [SLOT_W-1:0] rq_slot, sel_slot;
    logic [IDX_W-1:0]  rq_idx;
    logic              rq_ok;
    bclru_pkg::t_rsp   rsp;
    logic              ref_en, tag_we, tag_set, tag_clr, wr_set, wr_clr;
    logic [IDX_W-1:0]  ref_idx;
    logic              set_rd, clr_rd, set_wr, clr_wr;

    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_out_data     = r_out;

    assign p_slot   = SLOT_W'(r_p_idx);
    assign stamp_e  = r_stamp_vld[r_p_idx] ? r_rd_stamp : ST_W'(r_p_idx) + ST_W'(1);
    assign tag_hit  = r_tag_vld[r_p_idx] &&
                      (r_rd_tag == {r_req.ark_number, r_req.block_number});
    assign only_unw = (r_req.req_type == bclru_pkg::REQ_FIND_LRU) ? r_req.only_unwritten
                                                                  : 1'b1;
    assign lru_skip = (p_slot == r_rd_slot) || (p_slot == r_wr_slot) ||
                      (only_unw && r_written[r_p_idx]);
    assign lru_take = !lru_skip && (stamp_e < r_best);
    assign mru_take = (r_p_idx == '0) || (stamp_e > r_best);
    // refused write-back: every unwritten candidate gets marked written
    assign refuse_mark = r_p_vld && (r_req.req_type == bclru_pkg::REQ_START_WRITE) &&
                         (r_wr_slot == bclru_pkg::SLOT_NONE) && !r_req.store_accepts &&
                         !lru_skip && (stamp_e < r_cnt);

    assign n_cnt    = (r_cnt == '1) ? r_cnt : r_cnt + ST_W'(1);
    assign rq_slot  = {1'b0, r_req.entry_index};
    assign rq_idx   = rq_slot[IDX_W-1:0];
    assign rq_ok    = rq_slot < NUM_SLOT;
    assign sel_slot = SLOT_W'(r_sel);

    always_comb begin
        rsp     = '0;
        ref_en  = 1'b0;
        ref_idx = r_sel;
        tag_we  = 1'b0;
        tag_set = 1'b0;
        tag_clr = 1'b0;
        wr_set  = 1'b0;
        wr_clr  = 1'b0;
        set_rd  = 1'b0;
        clr_rd  = 1'b0;
        set_wr  = 1'b0;
        clr_wr  = 1'b0;
        unique case (r_req.req_type)
            bclru_pkg::REQ_LOOKUP: begin
                if (r_sel_vld && (sel_slot != r_rd_slot)) begin
                    ref_en    = 1'b1;
                    rsp.found = 1'b1;
                    rsp.entry = sel_slot[4:0];
                end
            end
            bclru_pkg::REQ_START_READ: begin
                ref_idx = rq_idx;
                if (rq_ok) begin
                    if (r_req.read_ok) begin
                        tag_we    = 1'b1;
                        tag_set   = 1'b1;
                        wr_clr    = 1'b1;
                        ref_en    = 1'b1;
                        set_rd    = 1'b1;
                        rsp.found = 1'b1;
                        rsp.entry = r_req.entry_index;
                    end else begin
                        tag_clr = 1'b1;
                        wr_set  = 1'b1;
                        clr_rd  = 1'b1;
                    end
                end
            end
            bclru_pkg::REQ_FINISH_READ: begin
                rsp.found = (r_rd_slot != bclru_pkg::SLOT_NONE);
                rsp.entry = rsp.found ? r_rd_slot[4:0] : 5'd0;
                clr_rd    = 1'b1;
            end
            bclru_pkg::REQ_FIND_LRU: begin
                rsp.found = r_sel_vld;
                rsp.entry = r_sel_vld ? sel_slot[4:0] : 5'd0;
            end
            bclru_pkg::REQ_FIND_MRU: begin
                rsp.found = 1'b1;
                rsp.entry = sel_slot[4:0];
            end
            bclru_pkg::REQ_START_WRITE: begin
                if (r_wr_slot != bclru_pkg::SLOT_NONE) begin
                    rsp.status = 1'b1;
                end else if (r_sel_vld && r_req.store_accepts) begin
                    wr_set    = 1'b1;
                    set_wr    = 1'b1;
                    rsp.found = 1'b1;
                    rsp.entry = sel_slot[4:0];
                end
            end
            bclru_pkg::REQ_FINISH_WRITE: begin
                rsp.found = (r_wr_slot != bclru_pkg::SLOT_NONE);
                rsp.entry = rsp.found ? r_wr_slot[4:0] : 5'd0;
                clr_wr    = 1'b1;
            end
            default: rsp = '0;
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && tag_we) begin
            mem_tag[rq_idx] <= {r_req.ark_number, r_req.block_number};
        end
        if (i_cmd.commit && ref_en) begin
            mem_stamp[ref_idx] <= n_cnt;
        end
        if (i_cmd.rd) begin
            r_rd_tag   <= mem_tag[i_cmd.rd_addr[IDX_W-1:0]];
            r_rd_stamp <= mem_stamp[i_cmd.rd_addr[IDX_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_p_idx <= i_cmd.rd_addr[IDX_W-1:0];
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.commit) begin
            r_out <= rsp;
        end
    end

    // control and directory state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld   <= '0;
            r_stamp_vld <= '0;
            r_written   <= '1;
            r_cnt       <= ST_W'(NUM_ENTRIES);
            r_rd_slot   <= bclru_pkg::SLOT_NONE;
            r_wr_slot   <= bclru_pkg::SLOT_NONE;
            r_p_vld     <= 1'b0;
            r_best      <= '0;
            r_sel       <= '0;
            r_sel_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.rd;

            if (i_cmd.load) begin
                r_best    <= r_cnt;
                r_sel     <= '0;
                r_sel_vld <= 1'b0;
            end else if (r_p_vld) begin
                case (r_req.req_type) inside
                    bclru_pkg::REQ_LOOKUP: begin
                        if (tag_hit && !r_sel_vld) begin
                            r_sel     <= r_p_idx;
                            r_sel_vld <= 1'b1;
                        end
                    end
                    bclru_pkg::REQ_FIND_LRU, bclru_pkg::REQ_START_WRITE: begin
                        if (lru_take) begin
                            r_best    <= stamp_e;
                            r_sel     <= r_p_idx;
                            r_sel_vld <= 1'b1;
                        end
                    end
                    bclru_pkg::REQ_FIND_MRU: begin
                        if (mru_take) begin
                            r_best    <= stamp_e;
                            r_sel     <= r_p_idx;
                            r_sel_vld <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end

            if (refuse_mark) begin
                r_written[r_p_idx] <= 1'b1;
            end

            if (i_cmd.commit) begin
                if (ref_en) begin
                    r_cnt                <= n_cnt;
                    r_stamp_vld[ref_idx] <= 1'b1;
                end
                if (tag_set) r_tag_vld[rq_idx] <= 1'b1;
                if (tag_clr) r_tag_vld[rq_idx] <= 1'b0;
                if (wr_clr)  r_written[rq_idx] <= 1'b0;
                if (wr_set && (r_req.req_type == bclru_pkg::REQ_START_WRITE)) begin
                    r_written[r_sel] <= 1'b1;
                end else if (wr_set) begin
                    r_written[rq_idx] <= 1'b1;
                end
                if (set_rd) r_rd_slot <= rq_slot;
                if (clr_rd) r_rd_slot <= bclru_pkg::SLOT_NONE;
                if (set_wr) r_wr_slot <= sel_slot;
                if (clr_wr) r_wr_slot <= bclru_pkg::SLOT_NONE;
            end

            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    `BCLRU_ASSERT_IMPL(a_rd_slot_range, i_clk, i_rst_n, 1'b1, r_rd_slot == bclru_pkg::SLOT_NONE || r_rd_slot < NUM_SLOT)
    `BCLRU_ASSERT_NEXT(a_finish_read, i_clk, i_rst_n, i_cmd.commit && r_req.req_type == bclru_pkg::REQ_FINISH_READ, r_rd_slot == bclru_pkg::SLOT_NONE)
    `BCLRU_ASSERT_IMPL(a_commit_free, i_clk, i_rst_n, i_cmd.commit, !r_out_vld || i_out_ready)

endmodule

// ===== rtl/core/block_cache_lru_directory.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_cache_lru_directory
// Directory of a fully associative block cache with timestamp LRU.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid/o_in_ready with i_in_data; one response per
//   request leaves on o_out_valid/i_out_ready with o_out_data.
//   One request is in flight at a time. Lookup, find LRU, find MRU and start
//   write sweep the tag/stamp memories one entry per cycle through a single
//   read port, then pass through a wait state to the commit state. Start read,
//   finish read, finish write and unknown types go from acceptance straight
//   to the commit state. o_in_ready returns high in the cycle the response
//   appears; the block cannot take a new request before then.
//   The response sits in an output register; the block takes the next request
//   while it waits, and only holds off the following commit until the
//   receiver drains it.
//   Reset is immediate: per-entry valid bits make every entry read as its
//   reset tag and stamp, no clearing pass is needed.
// ----------------------------------------------------------------------------
module block_cache_lru_directory #(
    parameter int NUM_ENTRIES = 19
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bclru_pkg::t_req i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bclru_pkg::t_rsp o_out_data
);

    bclru_pkg::t_cmd cmd;
    bclru_pkg::t_sts sts;

    bclru_ctrl #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_data.req_type),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bclru_dpath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
